[design/rfr_pkg.sv]
// Package for the radio frame receiver.
// Types, codes, default sizes and the CRC-8 step for the receiver modules.
// No dependencies.
package rfr_pkg;

  localparam int RING_DEPTH_DEF    = 128;
  localparam int STAGING_DEPTH_DEF = 128;
  localparam int TIMEOUT_BYTES_DEF = 256;

  localparam logic [7:0] STUFF_LO       = 8'h00;
  localparam logic [7:0] STUFF_HI       = 8'hFF;
  localparam logic [7:0] FRAME_TYPE_RST = 8'h19;
  localparam logic [7:0] NODE_ADDR_RST  = 8'h00;
  localparam logic [7:0] LAST_ID_RST    = 8'hFF;
  localparam logic [7:0] CRC_POLY       = 8'h8C;
  localparam logic [7:0] CRC_INIT       = 8'h00;

  localparam logic REG_NODE_ADDR  = 1'b0;
  localparam logic REG_FRAME_TYPE = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_DUP_ID   = 3'd2,
    EV_CRC_ERR  = 3'd3,
    EV_NOT_ME   = 3'd4,
    EV_TIMEOUT  = 3'd5,
    EV_OVERSIZE = 3'd6
  } frame_event_t;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_LEN    = 3'd1,
    PH_DEST   = 3'd2,
    PH_SRC    = 3'd3,
    PH_ID     = 3'd4,
    PH_DATA   = 3'd5,
    PH_CRC    = 3'd6,
    PH_IGNORE = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_BYTE,
    ST_COPY,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic read_step;
    logic byte_step;
    logic copy_step;
    logic out_load;
  } rfr_cmd_t;

  typedef struct packed {
    logic is_read;
    logic store;
    logic copy_done;
    logic out_free;
  } rfr_status_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/rfr_in_if.sv]
// Input request channel of the radio frame receiver.
// Depends on nothing.
interface rfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] radio_byte;

  modport source (output valid, output func, output radio_byte, input ready);
  modport sink   (input valid, input func, input radio_byte, output ready);
endinterface

[design/rfr_out_if.sv]
// Result channel of the radio frame receiver.
// Depends on nothing.
interface rfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic       data_available;
  logic [2:0] frame_event;
  logic       overflow_truncated;

  modport source (output valid, output read_data, output read_valid, output data_available,
                  output frame_event, output overflow_truncated, input ready);
  modport sink   (input valid, input read_data, input read_valid, input data_available,
                  input frame_event, input overflow_truncated, output ready);
endinterface

[design/radio_frame_receiver.sv]
// Radio frame receiver top level: one request at a time; the request is captured, handled
// in the byte state and its result loaded in the result state, which waits while a previous
// result still waits for out_ch.ready, before the next request can be taken. A stored frame's
// CRC byte adds a copy of staging memory into the ring, cut short when the ring fills.
// Synchronous active-high reset clears parser, ring pointers and handshake state;
// staging and ring memories are not cleared. Depends on rfr_pkg, rfr_in_if, rfr_out_if.
module radio_frame_receiver
  import rfr_pkg::*;
#(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int STAGING_DEPTH = STAGING_DEPTH_DEF,
  parameter int TIMEOUT_BYTES = TIMEOUT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rfr_in_if.sink      in_ch,
  rfr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  node_addr;
  logic [7:0]  frame_type;
  logic        cfg_we;
  rfr_cmd_t    cmd;
  rfr_status_t status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_addr  <= NODE_ADDR_RST;
      frame_type <= FRAME_TYPE_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_NODE_ADDR:  node_addr  <= pwdata[7:0];
        REG_FRAME_TYPE: frame_type <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NODE_ADDR:  prdata = {24'd0, node_addr};
      REG_FRAME_TYPE: prdata = {24'd0, frame_type};
      default:        prdata = '0;
    endcase
  end

  assign in_ch.ready = cmd.in_ready;

  rfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  rfr_dp #(
    .RING_DEPTH    (RING_DEPTH),
    .STAGING_DEPTH (STAGING_DEPTH),
    .TIMEOUT_BYTES (TIMEOUT_BYTES)
  ) u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .node_addr              (node_addr),
    .frame_type             (frame_type),
    .in_func                (in_ch.func),
    .in_radio_byte          (in_ch.radio_byte),
    .out_ready              (out_ch.ready),
    .cmd                    (cmd),
    .status                 (status),
    .out_valid              (out_ch.valid),
    .out_read_data          (out_ch.read_data),
    .out_read_valid         (out_ch.read_valid),
    .out_data_available     (out_ch.data_available),
    .out_frame_event        (out_ch.frame_event),
    .out_overflow_truncated (out_ch.overflow_truncated)
  );

endmodule

[design/rfr_ctrl.sv]
// Controller of the radio frame receiver: sequences accept, parse or ring read, copy and result.
// Depends on rfr_pkg.
module rfr_ctrl
  import rfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  rfr_status_t status,
  output rfr_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (status.is_read) begin
          cmd.read_step = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          cmd.byte_step = 1'b1;
          state_next    = status.store ? ST_COPY : ST_RESULT;
        end
      end
      ST_READ: begin
        cmd.read_step = 1'b1;
        state_next    = ST_RESULT;
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (status.copy_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/rfr_dp.sv]
// Datapath of the radio frame receiver: destuffing, header parse, CRC-8,
// staging memory, receive ring and result register. Depends on rfr_pkg.
module rfr_dp
  import rfr_pkg::*;
#(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int STAGING_DEPTH = STAGING_DEPTH_DEF,
  parameter int TIMEOUT_BYTES = TIMEOUT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  node_addr,
  input  logic [7:0]  frame_type,
  input  logic        in_func,
  input  logic [7:0]  in_radio_byte,
  input  logic        out_ready,
  input  rfr_cmd_t    cmd,
  output rfr_status_t status,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_data_available,
  output logic [2:0]  out_frame_event,
  output logic        out_overflow_truncated
);

  localparam int RW = $clog2(RING_DEPTH);
  localparam int SW = $clog2(STAGING_DEPTH);
  localparam int CW = $clog2(TIMEOUT_BYTES + 1);

  // captured request
  logic       item_func;
  logic [7:0] item_byte;

  // parser state
  phase_t        phase, phase_next;
  logic [7:0]    payload_length, payload_length_next;
  logic [7:0]    dest_address, dest_address_next;
  logic [7:0]    packet_id, packet_id_next;
  logic [7:0]    running_crc, running_crc_next;
  logic [7:0]    payload_count, payload_count_next;
  logic [7:0]    last_id, last_id_next;
  logic          skip_stuff, skip_stuff_next;
  logic [CW-1:0] bytes_since, bytes_since_next;
  frame_event_t  ev_next;
  logic          store_frame;
  logic          stg_we;

  logic [7:0]    crc_in, crc_out;
  logic [CW-1:0] cnt_base;
  logic [CW:0]   cnt_inc;
  logic [7:0]    count_inc;

  // memories
  logic [7:0] staging_mem [STAGING_DEPTH];
  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] stg_q;
  logic [7:0] ring_q;

  // ring and copy control
  logic [RW-1:0] ring_head, ring_tail;
  logic [RW-1:0] head_inc, tail_inc;
  logic [7:0]    copy_idx;
  logic          stg_vld;
  logic          rd_more;
  logic          ring_full;
  logic          ring_we;

  // result
  frame_event_t ev_q;
  logic         trunc_q;
  logic         rvalid_q;

  assign head_inc = (ring_head == RW'(RING_DEPTH - 1)) ? '0 : ring_head + 1'b1;
  assign tail_inc = (ring_tail == RW'(RING_DEPTH - 1)) ? '0 : ring_tail + 1'b1;

  assign crc_in    = (phase == PH_TYPE) ? CRC_INIT : running_crc;
  assign crc_out   = crc8_step(crc_in, item_byte);
  assign count_inc = payload_count + 8'd1;
  assign cnt_base  = (phase == PH_CRC) ? '0 : bytes_since;
  assign cnt_inc   = {1'b0, cnt_base} + (CW + 1)'(1);

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    dest_address_next   = dest_address;
    packet_id_next      = packet_id;
    running_crc_next    = running_crc;
    payload_count_next  = payload_count;
    last_id_next        = last_id;
    skip_stuff_next     = skip_stuff;
    bytes_since_next    = bytes_since;
    ev_next             = EV_NONE;
    store_frame         = 1'b0;
    stg_we              = 1'b0;
    if (skip_stuff) begin
      skip_stuff_next = 1'b0;
    end else begin
      skip_stuff_next = (item_byte == STUFF_LO) || (item_byte == STUFF_HI);
      unique case (phase)
        PH_TYPE: begin
          if (item_byte == frame_type) begin
            running_crc_next = crc_out;
            phase_next       = PH_LEN;
          end else begin
            phase_next = PH_IGNORE;
          end
        end
        PH_LEN: begin
          payload_length_next = item_byte;
          running_crc_next    = crc_out;
          if (item_byte > 8'(STAGING_DEPTH)) begin
            ev_next    = EV_OVERSIZE;
            phase_next = PH_IGNORE;
          end else begin
            phase_next = PH_DEST;
          end
        end
        PH_DEST: begin
          dest_address_next = item_byte;
          running_crc_next  = crc_out;
          phase_next        = PH_SRC;
        end
        PH_SRC: begin
          running_crc_next = crc_out;
          phase_next       = PH_ID;
        end
        PH_ID: begin
          packet_id_next     = item_byte;
          running_crc_next   = crc_out;
          payload_count_next = '0;
          phase_next         = (payload_length == 8'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          stg_we             = 1'b1;
          running_crc_next   = crc_out;
          payload_count_next = count_inc;
          if (count_inc >= payload_length) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_next = PH_TYPE;
          if (item_byte != running_crc) begin
            ev_next = EV_CRC_ERR;
          end else if (dest_address != node_addr) begin
            ev_next = EV_NOT_ME;
          end else if (packet_id == last_id) begin
            ev_next = EV_DUP_ID;
          end else begin
            ev_next      = EV_STORED;
            last_id_next = packet_id;
            store_frame  = 1'b1;
          end
        end
        PH_IGNORE: begin
        end
      endcase
      if (cnt_inc > (CW + 1)'(TIMEOUT_BYTES)) begin
        phase_next       = PH_TYPE;
        bytes_since_next = '0;
        if (ev_next == EV_NONE) begin
          ev_next = EV_TIMEOUT;
        end
      end else begin
        bytes_since_next = cnt_inc[CW-1:0];
      end
    end
  end

  assign rd_more   = (copy_idx < payload_length);
  assign ring_full = (head_inc == ring_tail);
  assign ring_we   = cmd.copy_step && stg_vld && !ring_full;

  always_comb begin
    status.is_read   = item_func;
    status.store     = store_frame && (payload_length != 8'd0);
    status.copy_done = (stg_vld && ring_full) || (!rd_more && !stg_vld);
    status.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func <= in_func;
      item_byte <= in_radio_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TYPE;
      payload_length <= '0;
      dest_address   <= '0;
      packet_id      <= '0;
      running_crc    <= '0;
      payload_count  <= '0;
      last_id        <= LAST_ID_RST;
      skip_stuff     <= 1'b0;
      bytes_since    <= '0;
    end else if (cmd.byte_step) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      dest_address   <= dest_address_next;
      packet_id      <= packet_id_next;
      running_crc    <= running_crc_next;
      payload_count  <= payload_count_next;
      last_id        <= last_id_next;
      skip_stuff     <= skip_stuff_next;
      bytes_since    <= bytes_since_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_step && stg_we) begin
      staging_mem[payload_count[SW-1:0]] <= item_byte;
    end
    stg_q <= staging_mem[copy_idx[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head_inc] <= stg_q;
    end
    if (cmd.read_step) begin
      ring_q <= ring_mem[tail_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head <= '0;
      ring_tail <= '0;
      copy_idx  <= '0;
      stg_vld   <= 1'b0;
      ev_q      <= EV_NONE;
      trunc_q   <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      if (cmd.byte_step) begin
        ev_q     <= ev_next;
        trunc_q  <= 1'b0;
        rvalid_q <= 1'b0;
        copy_idx <= '0;
        stg_vld  <= 1'b0;
      end
      if (cmd.read_step) begin
        ev_q     <= EV_NONE;
        trunc_q  <= 1'b0;
        rvalid_q <= (ring_head != ring_tail);
        if (ring_head != ring_tail) begin
          ring_tail <= tail_inc;
        end
      end
      if (cmd.copy_step) begin
        stg_vld  <= rd_more;
        copy_idx <= copy_idx + {7'd0, rd_more};
        if (ring_we) begin
          ring_head <= head_inc;
        end
        if (stg_vld && ring_full) begin
          trunc_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_data          <= rvalid_q ? ring_q : 8'd0;
      out_read_valid         <= rvalid_q;
      out_data_available     <= (ring_head != ring_tail);
      out_frame_event        <= ev_q;
      out_overflow_truncated <= trunc_q;
    end
  end

  a_copy_keeps_gap: assert property (@(posedge clk) disable iff (rst)
    ring_we |=> (ring_head != ring_tail))
    else $error("ring became empty after a copy write");

  a_trunc_only_stored: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && trunc_q) |-> (ev_q == EV_STORED))
    else $error("truncation flagged on a frame that was not stored");

  a_read_no_event: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && rvalid_q) |=> (out_frame_event == EV_NONE && out_read_valid))
    else $error("read result carries a frame event");

  a_single_owner: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.byte_step, cmd.read_step, cmd.copy_step, cmd.out_load}))
    else $error("datapath given more than one command");

endmodule

[sim/rfr_checker.sv]
// Result checker for the radio frame receiver: tracks register writes, predicts one
// result per accepted request and compares it with the result channel.
// Depends on rfr_pkg, rfr_in_if and rfr_out_if.
module rfr_checker
  import rfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rfr_in_if           in_ch,
  rfr_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          failures,
  output int          pending,
  output logic        parser_at_type
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING    = RING_DEPTH_DEF;
  localparam int STAGE   = STAGING_DEPTH_DEF;
  localparam int TIMEOUT = TIMEOUT_BYTES_DEF;

  localparam logic [2:0] ADDR_NODE_ADDR  = {REG_NODE_ADDR, 2'b00};
  localparam logic [2:0] ADDR_FRAME_TYPE = {REG_FRAME_TYPE, 2'b00};

  typedef struct packed {
    logic [7:0]   read_data;
    logic         read_valid;
    logic         data_available;
    frame_event_t frame_event;
    logic         overflow_truncated;
  } rx_result_t;

  rx_result_t expected_q[$];

  logic [7:0] node_addr;
  logic [7:0] parsed_type;
  phase_t     phase;
  int         payload_seen;
  logic [7:0] len_field;
  logic [7:0] dest_field;
  logic [7:0] id_field;
  logic [7:0] crc_acc;
  logic [7:0] last_id;
  bit         skip_next;
  int         since_end;
  logic [7:0] staging[STAGE];
  logic [7:0] ring[RING];
  int         head;
  int         tail;
  int         fails = 0;

  function automatic logic [7:0] crc8_dallas(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 8'h8C;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic commit_frame(input logic [7:0] crc_rx, output frame_event_t ev,
                              output logic trunc);
    int nxt;
    bit full;
    trunc = 1'b0;
    full = 1'b0;
    if (crc_rx != crc_acc) begin
      ev = EV_CRC_ERR;
    end else if (dest_field != node_addr) begin
      ev = EV_NOT_ME;
    end else if (id_field == last_id) begin
      ev = EV_DUP_ID;
    end else begin
      last_id = id_field;
      for (int i = 0; i < len_field && i < STAGE && !full; i++) begin
        nxt = (head + 1) % RING;
        if (nxt == tail) begin
          trunc = 1'b1;
          full = 1'b1;
        end else begin
          ring[nxt] = staging[i];
          head = nxt;
        end
      end
      ev = EV_STORED;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, output frame_event_t ev, output logic trunc);
    ev = EV_NONE;
    trunc = 1'b0;
    case (phase)
      PH_TYPE: begin
        if (b == parsed_type) begin
          crc_acc = crc8_dallas(CRC_INIT, b);
          phase = PH_LEN;
        end else begin
          phase = PH_IGNORE;
        end
      end
      PH_LEN: begin
        len_field = b;
        crc_acc = crc8_dallas(crc_acc, b);
        if (b > STAGE) begin
          ev = EV_OVERSIZE;
          phase = PH_IGNORE;
        end else begin
          phase = PH_DEST;
        end
      end
      PH_DEST: begin
        dest_field = b;
        crc_acc = crc8_dallas(crc_acc, b);
        phase = PH_SRC;
      end
      PH_SRC: begin
        crc_acc = crc8_dallas(crc_acc, b);
        phase = PH_ID;
      end
      PH_ID: begin
        id_field = b;
        crc_acc = crc8_dallas(crc_acc, b);
        payload_seen = 0;
        phase = (len_field == 8'd0) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        if (payload_seen < STAGE) staging[payload_seen] = b;
        crc_acc = crc8_dallas(crc_acc, b);
        payload_seen++;
        if (payload_seen >= len_field) phase = PH_CRC;
      end
      PH_CRC: begin
        commit_frame(b, ev, trunc);
        phase = PH_TYPE;
        since_end = 0;
      end
      default: ;
    endcase
    since_end++;
    if (since_end > TIMEOUT) begin
      phase = PH_TYPE;
      since_end = 0;
      if (ev == EV_NONE) ev = EV_TIMEOUT;
    end
  endtask

  task automatic predict(input logic is_read, input logic [7:0] b, output rx_result_t r);
    frame_event_t ev;
    logic trunc;
    r = '0;
    r.frame_event = EV_NONE;
    if (is_read) begin
      if (head != tail) begin
        tail = (tail + 1) % RING;
        r.read_data = ring[tail];
        r.read_valid = 1'b1;
      end
    end else if (skip_next) begin
      skip_next = 1'b0;
    end else begin
      if (b == STUFF_LO || b == STUFF_HI) skip_next = 1'b1;
      parse_byte(b, ev, trunc);
      r.frame_event = ev;
      r.overflow_truncated = trunc;
    end
    r.data_available = (head != tail);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    rx_result_t want;
    if (rst) begin
      expected_q.delete();
      node_addr = NODE_ADDR_RST;
      parsed_type = FRAME_TYPE_RST;
      phase = PH_TYPE;
      payload_seen = 0;
      len_field = '0;
      dest_field = '0;
      id_field = '0;
      crc_acc = '0;
      last_id = LAST_ID_RST;
      skip_next = 1'b0;
      since_end = 0;
      head = 0;
      tail = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_NODE_ADDR:  node_addr = pwdata[7:0];
          ADDR_FRAME_TYPE: parsed_type = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $error("result arrived with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("read_data", want.read_data, out_ch.read_data);
          check_field("read_valid", want.read_valid, out_ch.read_valid);
          check_field("data_available", want.data_available, out_ch.data_available);
          check_field("frame_event", want.frame_event, out_ch.frame_event);
          check_field("overflow_truncated", want.overflow_truncated,
                      out_ch.overflow_truncated);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict(in_ch.func, in_ch.radio_byte, want);
        expected_q.push_back(want);
      end
    end
    failures <= fails;
    pending <= expected_q.size();
    parser_at_type <= (phase == PH_TYPE) && !skip_next;
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the radio frame receiver: clock, reset, register writes, framed
// radio traffic with stuffing, ring reads and the verdict. Depends on rfr_pkg, the
// channel interfaces, radio_frame_receiver and rfr_checker.
module tb_top
  import rfr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS          = 1300;
  localparam int CFG_EVERY      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 150;

  localparam logic [2:0] ADDR_NODE_ADDR  = {REG_NODE_ADDR, 2'b00};
  localparam logic [2:0] ADDR_FRAME_TYPE = {REG_FRAME_TYPE, 2'b00};

  typedef enum int {
    SC_FRAME, SC_NOT_ME, SC_BAD_CRC, SC_DUP, SC_OVERFLOW,
    SC_READS, SC_OVERSIZE, SC_WRONG_TYPE, SC_CUT, SC_PAUSE
  } scenario_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int   failures;
  int   pending;
  logic parser_at_type;

  bit         calm = 1'b0;
  int         sent = 0;
  int         quiet = 0;
  logic [7:0] node_addr;
  logic [7:0] parsed_type;
  logic [7:0] last_my_id;

  rfr_in_if  in_ch();
  rfr_out_if out_ch();

  radio_frame_receiver uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rfr_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .failures       (failures),
    .pending        (pending),
    .parser_at_type (parser_at_type)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 8'h8C;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return STUFF_LO;
      1: return STUFF_HI;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] stuff_byte();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? STUFF_HI : STUFF_LO;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 8));
    return 8'($urandom_range(9, 40));
  endfunction

  task automatic send_req(input logic is_read, input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= is_read;
    in_ch.radio_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
  endtask

  task automatic configure(input logic [7:0] addr, input logic [7:0] kind);
    drain();
    apb_write(ADDR_NODE_ADDR, addr);
    apb_write(ADDR_FRAME_TYPE, kind);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    node_addr = addr;
    parsed_type = kind;
  endtask

  // cut < 0 sends the whole frame, otherwise only its first cut bytes
  task automatic send_frame(input logic [7:0] kind, len, dest, src, pid,
                            input bit corrupt, input int cut);
    logic [7:0] fb[$];
    logic [7:0] crc;
    int n;
    fb.push_back(kind);
    fb.push_back(len);
    fb.push_back(dest);
    fb.push_back(src);
    fb.push_back(pid);
    if (len <= STAGING_DEPTH_DEF) begin
      for (int i = 0; i < len; i++) fb.push_back(payload_byte());
    end
    crc = CRC_INIT;
    foreach (fb[i]) crc = crc8_maxim(crc, fb[i]);
    fb.push_back(corrupt ? crc ^ 8'($urandom_range(1, 255)) : crc);
    n = (cut < 0 || cut > fb.size()) ? fb.size() : cut;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_req(1'b1, 8'($urandom));
      send_req(1'b0, fb[i]);
      if (fb[i] == STUFF_LO || fb[i] == STUFF_HI) send_req(1'b0, stuff_byte());
    end
  endtask

  // feed filler until the parser waits for a type byte again
  task automatic resync();
    drain();
    while (parser_at_type !== 1'b1) begin
      send_req(1'b0, 8'($urandom));
      drain();
    end
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int step;
    int r;
    int len;
    int cfg_round;
    int next_cfg;
    scenario_t pick;
    logic [7:0] dest;
    logic [7:0] pid;
    bit corrupt;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.func <= 1'b0;
    in_ch.radio_byte <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    configure(NODE_ADDR_RST, FRAME_TYPE_RST);
    send_req(1'b1, 8'hFF);
    send_frame(parsed_type, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, -1);
    send_frame(parsed_type, 8'd2, 8'h00, 8'h01, 8'h7F, 1'b0, -1);
    last_my_id = 8'h7F;
    repeat (3) send_req(1'b1, 8'h00);

    step = 0;
    cfg_round = 0;
    next_cfg = CFG_EVERY;
    while (sent < ITEMS) begin
      if (sent >= next_cfg) begin
        case (cfg_round)
          0: configure(8'hFF, 8'hFF);
          1: configure(8'h00, 8'h00);
          default: configure(8'($urandom), ($urandom_range(0, 1) != 0) ? FRAME_TYPE_RST
                                                                     : 8'($urandom));
        endcase
        cfg_round++;
        next_cfg += CFG_EVERY;
      end
      if ($urandom_range(0, 7) == 0) calm = !calm;
      if (step <= SC_PAUSE) begin
        pick = scenario_t'(step);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) pick = SC_FRAME;
        else if (r < 82) pick = SC_READS;
        else if (r < 87) pick = SC_DUP;
        else if (r < 90) pick = SC_OVERFLOW;
        else if (r < 92) pick = SC_OVERSIZE;
        else if (r < 94) pick = SC_WRONG_TYPE;
        else if (r < 96) pick = SC_CUT;
        else pick = SC_PAUSE;
      end
      step++;
      case (pick)
        SC_FRAME, SC_NOT_ME, SC_BAD_CRC: begin
          if (pick == SC_NOT_ME) dest = node_addr ^ 8'($urandom_range(1, 255));
          else if (pick == SC_FRAME && $urandom_range(0, 4) == 0) dest = 8'($urandom);
          else dest = node_addr;
          corrupt = (pick == SC_BAD_CRC) || (pick == SC_FRAME && $urandom_range(0, 9) == 0);
          pid = ($urandom_range(0, 3) == 0) ? last_my_id : 8'($urandom);
          send_frame(parsed_type, pick_len(), dest, 8'($urandom), pid, corrupt, -1);
          if (dest == node_addr && !corrupt) last_my_id = pid;
        end
        SC_DUP: begin
          send_frame(parsed_type, pick_len(), node_addr, 8'($urandom), last_my_id, 1'b0, -1);
        end
        SC_OVERFLOW: begin
          repeat (2) begin
            last_my_id++;
            send_frame(parsed_type, 8'($urandom_range(100, 128)), node_addr, 8'($urandom),
                       last_my_id, 1'b0, -1);
          end
        end
        SC_READS: begin
          repeat ($urandom_range(1, 24)) send_req(1'b1, 8'($urandom));
        end
        SC_OVERSIZE: begin
          send_frame(parsed_type, 8'($urandom_range(129, 255)), node_addr, 8'($urandom),
                     8'($urandom), 1'b0, 2);
          resync();
        end
        SC_WRONG_TYPE: begin
          send_frame(parsed_type ^ 8'($urandom_range(1, 255)), 8'd4, node_addr,
                     8'($urandom), 8'($urandom), 1'b0, $urandom_range(1, 10));
          resync();
        end
        SC_CUT: begin
          len = $urandom_range(1, 16);
          send_frame(parsed_type, 8'(len), node_addr, 8'($urandom), 8'($urandom), 1'b0,
                     $urandom_range(1, len + 5));
          resync();
        end
        default: drain();
      endcase
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
